// ===== rtl/tdtb_pkg.sv =====
// Shared types and constants for the tick-driven timer bank.
// No dependencies; every other file but tdtb_checker imports this package.
package tdtb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TICK_WIDTH = 24;
  localparam int IVL_W      = 24;
  localparam int ACT_W      = 3;
  localparam int TIDX_W     = 4;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int TL_W       = TICK_WIDTH + 1;

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK     = 3'd0,
    ACT_INIT     = 3'd1,
    ACT_SHUTDOWN = 3'd2,
    ACT_START    = 3'd3,
    ACT_STOP     = 3'd4,
    ACT_CHECK    = 3'd5,
    ACT_DISABLE  = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MODIFY,
    ST_DONE
  } state_t;

  // One timer's state as held in the store.
  typedef struct packed {
    logic [TL_W-1:0]       ticks_left;  // signed remaining count
    logic [TICK_WIDTH-1:0] reload;      // zero means stopped
    logic                  expired;
    logic                  one_shot;
    logic                  init;
    logic                  disabled;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

endpackage

// ===== rtl/tick_driven_timer_bank_core.sv =====
// Bank of NUM_TIMERS periodic / one-shot countdown timers on a shared tick.
// Each input transaction carries one action and yields exactly one result
// transaction (expired is 1 only for a check that finds the timer expired).
// Sequencing: tick, action code 7 and any action but a pending-tick check on an
// index outside the bank finish with no memory access; init, shutdown, start,
// stop, set disable and a check with no pending ticks do one memory read and
// one write-back. A check with pending ticks first walks the whole bank through
// the single timer memory, one entry per cycle with read and write-back
// overlapped. One action is in flight at a time; the output register lets the
// next transaction enter while a result waits.
// Timer state sits in one synchronous memory; per-entry valid bits return
// zero for entries never written, so there is no clearing pass after reset.
// Depends on tdtb_pkg, tdtb_ctrl and tdtb_store.
module tick_driven_timer_bank_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tdtb_pkg::ACT_W-1:0]    action,
  input  logic [tdtb_pkg::TIDX_W-1:0]   timer_index,
  input  logic [tdtb_pkg::IVL_W-1:0]    interval_ticks,
  input  logic                          one_shot,
  input  logic                          disable_flag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          expired
);
  import tdtb_pkg::*;

  mem_req_t req;
  entry_t   rd_data;
  logic     done;
  logic     done_expired;
  logic     out_free;

  // Output slot is free when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;

  tdtb_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .timer_index    (timer_index),
    .interval_ticks (interval_ticks),
    .one_shot       (one_shot),
    .disable_flag   (disable_flag),
    .out_free       (out_free),
    .done           (done),
    .done_expired   (done_expired),
    .req            (req),
    .rd_data        (rd_data)
  );

  tdtb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      expired <= done_expired;
    end
  end

endmodule

// ===== rtl/tdtb_store.sv =====
// Timer state memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as all zero after reset.
// Depends on tdtb_pkg.
module tdtb_store (
  input  logic              clk,
  input  logic              rst,
  input  tdtb_pkg::mem_req_t req,
  output tdtb_pkg::entry_t  rd_data
);
  import tdtb_pkg::*;

  entry_t                 mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  // Read with write-to-read forwarding on an address match.
  always_ff @(posedge clk) begin
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rd_data <= req.wdata;
      end else if (valid[req.raddr]) begin
        rd_data <= mem[req.raddr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ===== rtl/tdtb_ctrl.sv =====
// Command sequencer: tick counting, bank walk and indexed read-modify-write.
// Depends on tdtb_pkg; drives the tdtb_store request port.
module tdtb_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tdtb_pkg::ACT_W-1:0]    action,
  input  logic [tdtb_pkg::TIDX_W-1:0]   timer_index,
  input  logic [tdtb_pkg::IVL_W-1:0]    interval_ticks,
  input  logic                          one_shot,
  input  logic                          disable_flag,
  input  logic                          out_free,
  output logic                          done,
  output logic                          done_expired,
  output tdtb_pkg::mem_req_t            req,
  input  tdtb_pkg::entry_t              rd_data
);
  import tdtb_pkg::*;

  state_t                state, state_next;
  action_t               cmd_action, cmd_action_next;
  logic [IDX_W-1:0]      cmd_idx, cmd_idx_next;
  logic                  cmd_inside, cmd_inside_next;
  logic [TICK_WIDTH-1:0] cmd_ivl, cmd_ivl_next;
  logic                  cmd_one_shot, cmd_one_shot_next;
  logic                  cmd_dis, cmd_dis_next;
  logic [TICK_WIDTH-1:0] pending, pending_next;
  logic [CNT_W-1:0]      init_cnt, init_cnt_next;
  logic [IDX_W-1:0]      walk_idx, walk_idx_next;
  logic                  res, res_next;

  action_t               in_act;
  logic                  in_inside;
  logic [TICK_WIDTH-1:0] in_ivl;
  logic                  walk_last;
  logic                  walk_active;
  logic signed [TL_W-1:0] walk_diff;
  entry_t                walk_entry;

  assign in_act    = action_t'(action);
  assign in_inside = (32'(timer_index) < NUM_TIMERS);
  assign in_ivl    = (TICK_WIDTH'(interval_ticks) == '0) ? TICK_WIDTH'(1)
                                                          : TICK_WIDTH'(interval_ticks);
  assign walk_last = (walk_idx == IDX_W'(NUM_TIMERS - 1));

  assign in_stall     = (state != ST_IDLE);
  assign done         = (state == ST_DONE);
  assign done_expired = res;

  // Pending-tick update of the entry under the walk.
  assign walk_active = rd_data.init && !rd_data.disabled && (rd_data.reload != '0);
  assign walk_diff   = $signed(rd_data.ticks_left) - $signed({1'b0, pending});

  always_comb begin
    walk_entry = rd_data;
    if (walk_active) begin
      if (walk_diff <= 0) begin
        walk_entry.ticks_left = {1'b0, rd_data.reload};
        walk_entry.expired    = 1'b1;
      end else begin
        walk_entry.ticks_left = walk_diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pending  <= '0;
      init_cnt <= '0;
    end else begin
      state    <= state_next;
      pending  <= pending_next;
      init_cnt <= init_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_action   <= cmd_action_next;
    cmd_idx      <= cmd_idx_next;
    cmd_inside   <= cmd_inside_next;
    cmd_ivl      <= cmd_ivl_next;
    cmd_one_shot <= cmd_one_shot_next;
    cmd_dis      <= cmd_dis_next;
    walk_idx     <= walk_idx_next;
    res          <= res_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_act)
            ACT_TICK: state_next = ST_DONE;
            ACT_CHECK: begin
              if (pending != '0)  state_next = ST_WALK;
              else if (in_inside) state_next = ST_MODIFY;
              else                state_next = ST_DONE;
            end
            ACT_INIT, ACT_SHUTDOWN, ACT_START, ACT_STOP, ACT_DISABLE: begin
              state_next = in_inside ? ST_MODIFY : ST_DONE;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_last) state_next = cmd_inside ? ST_MODIFY : ST_DONE;
      end
      ST_MODIFY: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    req               = '0;
    cmd_action_next   = cmd_action;
    cmd_idx_next      = cmd_idx;
    cmd_inside_next   = cmd_inside;
    cmd_ivl_next      = cmd_ivl;
    cmd_one_shot_next = cmd_one_shot;
    cmd_dis_next      = cmd_dis;
    pending_next      = pending;
    init_cnt_next     = init_cnt;
    walk_idx_next     = walk_idx;
    res_next          = res;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_action_next   = in_act;
          cmd_idx_next      = IDX_W'(timer_index);
          cmd_inside_next   = in_inside;
          cmd_ivl_next      = in_ivl;
          cmd_one_shot_next = one_shot;
          cmd_dis_next      = disable_flag;
          res_next          = 1'b0;
          case (in_act)
            ACT_TICK: begin
              if ((init_cnt != '0) && (pending != TICK_MAX)) begin
                pending_next = pending + TICK_WIDTH'(1);
              end
            end
            ACT_CHECK: begin
              if (pending != '0) begin
                req.re        = 1'b1;
                req.raddr     = '0;
                walk_idx_next = '0;
              end else if (in_inside) begin
                req.re    = 1'b1;
                req.raddr = IDX_W'(timer_index);
              end
            end
            ACT_INIT, ACT_SHUTDOWN, ACT_START, ACT_STOP, ACT_DISABLE: begin
              req.re    = in_inside;
              req.raddr = IDX_W'(timer_index);
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        req.we    = 1'b1;
        req.waddr = walk_idx;
        req.wdata = walk_entry;
        if (!walk_last) begin
          req.re        = 1'b1;
          req.raddr     = walk_idx + IDX_W'(1);
          walk_idx_next = walk_idx + IDX_W'(1);
        end else begin
          pending_next = '0;
          req.re       = cmd_inside;   // forwarded by the store on a match
          req.raddr    = cmd_idx;
        end
      end
      ST_MODIFY: begin
        req.we    = 1'b1;
        req.waddr = cmd_idx;
        req.wdata = rd_data;
        case (cmd_action)
          ACT_INIT: begin
            req.wdata.one_shot = cmd_one_shot;
            req.wdata.init     = 1'b1;
            if (!rd_data.init) begin
              init_cnt_next = init_cnt + CNT_W'(1);
              if (init_cnt == '0) pending_next = '0;
            end
          end
          ACT_SHUTDOWN: begin
            req.wdata.reload = '0;
            req.wdata.init   = 1'b0;
            if (rd_data.init) init_cnt_next = init_cnt - CNT_W'(1);
          end
          ACT_START: begin
            req.wdata.expired    = 1'b0;
            req.wdata.reload     = cmd_ivl;
            req.wdata.ticks_left = {1'b0, cmd_ivl};
          end
          ACT_STOP: req.wdata.reload = '0;
          ACT_CHECK: begin
            if (rd_data.expired) begin
              res_next          = 1'b1;
              req.wdata.expired = 1'b0;
              if (rd_data.one_shot) req.wdata.reload = '0;
            end
          end
          ACT_DISABLE: req.wdata.disabled = cmd_dis;
          default: req.we = 1'b0;
        endcase
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

// ===== rtl/tdtb_checker.sv =====
// Port-level checks for the timer bank, attached to the top level by bind.
// Depends on tick_driven_timer_bank_core port names only.
module tdtb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic expired
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(expired))
    else $error("stalled result changed");

  // One action in flight: accepting a transaction closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // A new result only appears from a busy sequencer.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an accepted action");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind tick_driven_timer_bank_core tdtb_checker u_tdtb_checker (.*);
